FILE: rtl/cca_pkg.sv
package cca_pkg;

  localparam int MAX_CELLS_DEF = 256;
  localparam int CFG_DATA_W    = 9;
  localparam int CFG_INDEX_W   = 2;

  // config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_INSTALLED = 2'd2;

  localparam logic [3:0] PLANE_COUNT_RST    = 4'd8;
  localparam logic [8:0] RESERVED_CELLS_RST = 9'd16;
  localparam logic       MAP_INSTALLED_RST  = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_ARGS  = 3'd1;
  localparam logic [2:0] STAT_TOO_MANY  = 3'd2;
  localparam logic [2:0] STAT_NO_ROOM   = 3'd3;
  localparam logic [2:0] STAT_RANGE     = 3'd4;
  localparam logic [2:0] STAT_NOT_ALLOC = 3'd5;

  typedef enum logic [1:0] {
    FLAG_AVAIL = 2'd0,
    FLAG_RO    = 2'd1,
    FLAG_ALLOC = 2'd2
  } flag_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  plane_bits;
    logic [8:0]  pixel_count;
    logic [7:0]  cell_index;
    logic [31:0] colour_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  base_cell;
    logic [8:0]  block_stride;
    logic        palette_write;
    logic [7:0]  palette_index;
    logic [31:0] palette_rgb;
  } out_word_t;

endpackage

FILE: rtl/cca_flag_store.sv
module cca_flag_store
  import cca_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  output logic          busy,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] rd_addr,
  input  logic [8:0]    reserved,
  output flag_t         rd_flag
);

  // Cells only ever move to allocated, so one bit per cell is the whole
  // state; an unset bit falls back to the init value from the config.
  // The bits are cleared one per cycle after reset and after clr; busy
  // stays high for the whole of that pass. Reads are registered.
  logic          alloc_mem [MAX_CELLS];
  logic          busy_r, busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] rd_addr_r;
  logic          rd_bit_r;
  logic          clr_last;

  assign clr_last = (clr_addr_r == AW'(MAX_CELLS - 1));
  assign busy     = busy_r;

  always_comb begin
    busy_nxt     = busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr) begin
      busy_nxt     = 1'b1;
      clr_addr_nxt = '0;
    end else if (busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      alloc_mem[clr_addr_r] <= 1'b0;
    end else if (wr_en) begin
      alloc_mem[wr_addr] <= 1'b1;
    end
    rd_bit_r  <= alloc_mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_comb begin
    if (rd_bit_r) begin
      rd_flag = FLAG_ALLOC;
    end else if (9'(rd_addr_r) < reserved) begin
      rd_flag = FLAG_RO;
    end else begin
      rd_flag = FLAG_AVAIL;
    end
  end

endmodule

FILE: rtl/colormap_cell_allocator.sv
// Colormap cell allocator.
// Input channel (in_valid/in_stall/in_data) takes one request word: an
// allocate of pixel_count blocks of 2^plane_bits aligned cells, or a store
// of an rgb word into an allocated cell. Each request yields exactly one
// result word on out_valid/out_stall/out_data.
// One request is worked at a time; in_stall is high from acceptance until
// the result has moved into the output register, and while cfg_valid is up.
// A store passes through the check and response states before out_valid.
// An allocate walks the flags one cell per cycle from cell 0 until a large
// enough aligned free run is seen (or the map end is reached), then
// marks the granted cells one per cycle and moves to the response state.
// A stalled result holds in the output register; a new request is still
// taken and its result waits in the sequencer until the register frees.
// Config writes (cfg_valid/cfg_ready) are taken while idle; any write to
// a defined register clears the allocation bits in a pass
// with in_stall high and cfg_ready low. Reset restores 8 planes,
// 16 reserved cells, map installed, and runs the same clearing pass.
module colormap_cell_allocator
  import cca_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int CW = AW + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  state_t    state_r, state_nxt;
  in_word_t  req_r, req_nxt;
  logic [3:0] plane_cnt_r, plane_cnt_nxt;
  logic [8:0] reserved_r, reserved_nxt;
  logic       installed_r, installed_nxt;
  logic [CW-1:0] ncells_r, ncells_nxt;
  logic [8:0]    block_r, block_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] end_r, end_nxt;
  out_word_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic [3:0]    p_eff;
  logic [8:0]    size9;
  logic [CW-1:0] map_size;
  logic          cfg_wr, cfg_hit;
  logic [16:0]   ncells_full;
  logic          bad_args, too_many;
  logic          at_end, cell_free, aligned, found, mark_last, out_free;
  logic [CW-1:0] run_inc;
  logic [AW-1:0] flag_rd_addr;
  flag_t         flag_rd;
  logic          flags_busy, in_take;

  // map size = 2^plane_count, plane count clamped to 1..8, capped at MAX_CELLS
  always_comb begin
    if (plane_cnt_r < 4'd1) begin
      p_eff = 4'd1;
    end else if (plane_cnt_r > 4'd8) begin
      p_eff = 4'd8;
    end else begin
      p_eff = plane_cnt_r;
    end
    size9 = 9'd1 << p_eff;
    map_size = (size9 > 9'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(size9);
  end

  assign in_stall  = (state_r != S_IDLE) || flags_busy || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !flags_busy;
  assign in_take   = in_valid && !in_stall;

  assign cfg_wr  = cfg_valid && cfg_ready;
  assign cfg_hit = cfg_wr && (cfg_index == CFG_PLANE_COUNT ||
                              cfg_index == CFG_RESERVED ||
                              cfg_index == CFG_MAP_INSTALLED);

  // flag read is registered: address the cell that is looked at next cycle
  assign flag_rd_addr = (state_r == S_IDLE) ? AW'(in_data.cell_index)
                                            : scan_idx_nxt[AW-1:0];

  cca_flag_store #(
    .MAX_CELLS(MAX_CELLS)
  ) u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_hit),
    .busy    (flags_busy),
    .wr_en   (state_r == S_MARK),
    .wr_addr (scan_idx_r[AW-1:0]),
    .rd_addr (flag_rd_addr),
    .reserved(reserved_r),
    .rd_flag (flag_rd)
  );

  // request checks; the shifted count is only meaningful for plane_bits <= 8
  assign ncells_full = 17'(req_r.pixel_count) << req_r.plane_bits;
  assign bad_args    = (req_r.pixel_count == 9'd0);
  assign too_many    = (req_r.plane_bits > 4'd8) || (ncells_full > 17'(map_size));

  // scan step
  assign at_end    = (scan_idx_r == map_size);
  assign cell_free = (flag_rd == FLAG_AVAIL);
  assign aligned   = ((9'(scan_idx_r) & (block_r - 9'd1)) == 9'd0);
  assign run_inc   = run_r + CW'(1);
  assign found     = !at_end && cell_free && (run_r != '0 || aligned) &&
                     (run_inc == ncells_r);
  assign mark_last = (scan_idx_r + CW'(1) == end_r);
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r.req_type == REQ_STORE || bad_args || too_many) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (at_end) begin
          state_nxt = S_RESP;
        end else if (found) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (mark_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt       = req_r;
    plane_cnt_nxt = plane_cnt_r;
    reserved_nxt  = reserved_r;
    installed_nxt = installed_r;
    ncells_nxt    = ncells_r;
    block_nxt     = block_r;
    scan_idx_nxt  = scan_idx_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_wr) begin
      case (cfg_index)
        CFG_PLANE_COUNT:   plane_cnt_nxt = cfg_data[3:0];
        CFG_RESERVED:      reserved_nxt  = cfg_data[8:0];
        CFG_MAP_INSTALLED: installed_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) req_nxt = in_data;
      end
      S_CHECK: begin
        res_nxt      = '0;
        ncells_nxt   = CW'(ncells_full);
        block_nxt    = 9'd1 << req_r.plane_bits;
        scan_idx_nxt = '0;
        run_nxt      = '0;
        start_nxt    = '0;
        if (req_r.req_type == REQ_STORE) begin
          if (9'(req_r.cell_index) >= 9'(map_size)) begin
            res_nxt.status = STAT_RANGE;
          end else if (flag_rd != FLAG_ALLOC) begin
            res_nxt.status = STAT_NOT_ALLOC;
          end else begin
            res_nxt.status = STAT_OK;
            if (installed_r) begin
              res_nxt.palette_write = 1'b1;
              res_nxt.palette_index = req_r.cell_index;
              res_nxt.palette_rgb   = req_r.colour_value;
            end
          end
        end else if (bad_args) begin
          res_nxt.status = STAT_BAD_ARGS;
        end else if (too_many) begin
          res_nxt.status = STAT_TOO_MANY;
        end
      end
      S_SCAN: begin
        if (at_end) begin
          res_nxt.status = STAT_NO_ROOM;
        end else begin
          // a run only starts counting on an aligned free cell
          if (!cell_free) begin
            run_nxt = '0;
          end else if (run_r != '0) begin
            run_nxt = run_inc;
          end else if (aligned) begin
            run_nxt   = CW'(1);
            start_nxt = scan_idx_r;
          end
          if (found) begin
            scan_idx_nxt = start_nxt;
            end_nxt      = start_nxt + ncells_r;
          end else begin
            scan_idx_nxt = scan_idx_r + CW'(1);
          end
        end
      end
      S_MARK: begin
        scan_idx_nxt = scan_idx_r + CW'(1);
        if (mark_last) begin
          res_nxt.status       = STAT_OK;
          res_nxt.base_cell    = 8'(start_r);
          res_nxt.block_stride = block_r;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plane_cnt_r <= PLANE_COUNT_RST;
      reserved_r  <= RESERVED_CELLS_RST;
      installed_r <= MAP_INSTALLED_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_cnt_r <= plane_cnt_nxt;
      reserved_r  <= reserved_nxt;
      installed_r <= installed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ncells_r   <= ncells_nxt;
    block_r    <= block_nxt;
    scan_idx_r <= scan_idx_nxt;
    run_r      <= run_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // never grant a cell twice
  a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (flag_rd == FLAG_AVAIL))
    else $error("marking a cell that is not available");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted word not checked next cycle");

  a_base_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STAT_OK && out_data_r.block_stride != 9'd0)
      |-> ((9'(out_data_r.base_cell) & (out_data_r.block_stride - 9'd1)) == 9'd0))
    else $error("granted base not on block boundary");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word without response state");

endmodule
